>>> rtl/sra_pkg.sv
// Shared constants, operation and status codes, and control structs of the stack ALU.
package sra_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int REG_COUNT   = 16;
    localparam int WORD_WIDTH  = 32;

    localparam int CMD_W   = 4;
    localparam int IDX_W   = 8;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int DEPTH_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_VAL = 4'd0,
        CMD_PUSH_REG = 4'd1,
        CMD_POP      = 4'd2,
        CMD_ADD      = 4'd3,
        CMD_SUB      = 4'd4,
        CMD_MUL      = 4'd5,
        CMD_DIV      = 4'd6,
        CMD_SET      = 4'd7,
        CMD_PEEK     = 4'd8
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_DIV_ZERO  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic md_start;
        logic finish;
    } t_ctl;

    typedef struct packed {
        logic need_md;
        logic md_done;
    } t_dp_stat;

endpackage

>>> rtl/sra_muldiv.sv
// Iterative shift-add multiplier and restoring signed divider, one bit per cycle.
module sra_muldiv #(
    parameter int WORD_WIDTH = sra_pkg::WORD_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_div,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic                  o_run,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_result
);

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(WORD_WIDTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(WORD_WIDTH - 1);

    logic          r_run;
    logic          r_done;
    logic          r_div;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_opa;
    logic [W-1:0]  r_opb;
    logic [W-2:0]  r_rem;

    logic [W-1:0]  w_mag_a;
    logic [W-1:0]  w_mag_b;
    logic [W-1:0]  w_shift;
    logic [W:0]    w_trial;
    logic          w_qbit;

    assign w_mag_a = i_a[W-1] ? (W'(0) - i_a) : i_a;
    assign w_mag_b = i_b[W-1] ? (W'(0) - i_b) : i_b;
    assign w_shift = {r_rem, r_opa[W-1]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_opb};
    assign w_qbit  = ~w_trial[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_acc <= '0;
            r_rem <= '0;
            r_opa <= i_div ? w_mag_a : i_a;
            r_opb <= i_div ? w_mag_b : i_b;
        end else if (r_run) begin
            if (r_div) begin
                r_rem <= w_qbit ? w_trial[W-2:0] : w_shift[W-2:0];
                r_opa <= {r_opa[W-2:0], w_qbit};
            end else begin
                if (r_opb[0]) begin
                    r_acc <= r_acc + r_opa;
                end
                r_opa <= {r_opa[W-2:0], 1'b0};
                r_opb <= {1'b0, r_opb[W-1:1]};
            end
        end
    end

    assign o_run    = r_run;
    assign o_done   = r_done;
    assign o_result = !r_div ? r_acc : (r_neg ? (W'(0) - r_opa) : r_opa);

endmodule

>>> rtl/sra_datapath.sv
// Datapath: register file, ring-buffer data stack, operation decode and result registers.
module sra_datapath #(
    parameter int STACK_DEPTH = sra_pkg::STACK_DEPTH,
    parameter int REG_COUNT   = sra_pkg::REG_COUNT,
    parameter int WORD_WIDTH  = sra_pkg::WORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sra_pkg::t_ctl                     i_ctl,
    output sra_pkg::t_dp_stat                 o_stat,
    input  logic        [sra_pkg::CMD_W-1:0]   i_cmd,
    input  logic        [sra_pkg::IDX_W-1:0]   i_reg_a,
    input  logic        [sra_pkg::IDX_W-1:0]   i_reg_b,
    input  logic signed [sra_pkg::VAL_W-1:0]   i_value,
    output logic signed [sra_pkg::VAL_W-1:0]   o_read_value,
    output logic        [sra_pkg::ST_W-1:0]    o_status,
    output logic        [sra_pkg::DEPTH_W-1:0] o_stack_depth,
    output logic                              o_done
);

    localparam int W  = WORD_WIDTH;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int IW = $clog2(REG_COUNT);
    localparam logic [AW-1:0] LAST_SLOT = AW'(STACK_DEPTH - 1);
    localparam logic [sra_pkg::IDX_W-1:0] REG_LIMIT = sra_pkg::IDX_W'(REG_COUNT);

    logic        [sra_pkg::CMD_W-1:0] r_cmd;
    logic        [sra_pkg::IDX_W-1:0] r_reg_a;
    logic        [sra_pkg::IDX_W-1:0] r_reg_b;
    logic signed [sra_pkg::VAL_W-1:0] r_value;

    logic [W-1:0]  r_rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [W-1:0]  r_rd_a;
    logic [W-1:0]  r_rd_b;
    logic          r_rd_a_v;
    logic          r_rd_b_v;

    logic [W-1:0]  r_stk_mem [STACK_DEPTH];
    logic [W-1:0]  r_stk_rd;
    logic [AW-1:0] r_top;
    logic [AW-1:0] r_depth;

    logic [sra_pkg::VAL_W-1:0]   r_out_rv;
    sra_pkg::t_status            r_out_st;
    logic [sra_pkg::DEPTH_W-1:0] r_out_depth;
    logic                        r_out_vld;

    logic [AW-1:0] w_top_inc;
    logic [AW-1:0] w_top_dec;
    logic          w_full;
    logic          w_a_ok;
    logic          w_b_ok;
    logic [W-1:0]  w_x;
    logic [W-1:0]  w_y;
    logic [W-1:0]  w_imm;
    logic          w_md_run;
    logic          w_md_done;
    logic [W-1:0]  w_md_result;

    logic [W-1:0]     n_rv;
    sra_pkg::t_status n_st;
    logic [AW-1:0]    n_top;
    logic [AW-1:0]    n_depth;
    logic             w_rf_we;
    logic [IW-1:0]    w_rf_wa;
    logic [W-1:0]     w_rf_wd;
    logic             w_stk_we;
    logic [W-1:0]     w_stk_wd;
    logic             w_need_md;

    assign w_top_inc = (r_top == LAST_SLOT) ? '0 : r_top + 1'b1;
    assign w_top_dec = (r_top == '0) ? LAST_SLOT : r_top - 1'b1;
    assign w_full    = (r_depth == LAST_SLOT);
    assign w_a_ok    = (r_reg_a < REG_LIMIT);
    assign w_b_ok    = (r_reg_b < REG_LIMIT);
    assign w_x       = r_rd_a_v ? r_rd_a : '0;
    assign w_y       = r_rd_b_v ? r_rd_b : '0;
    assign w_imm     = W'(r_value);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_reg_a <= i_reg_a;
            r_reg_b <= i_reg_b;
            r_value <= i_value;
        end
    end

    sra_muldiv #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.md_start),
        .i_div   (r_cmd == sra_pkg::CMD_DIV),
        .i_a     (w_x),
        .i_b     (w_y),
        .o_run   (w_md_run),
        .o_done  (w_md_done),
        .o_result(w_md_result)
    );

    always_comb begin
        n_rv      = '0;
        n_st      = sra_pkg::ST_OK;
        n_top     = r_top;
        n_depth   = r_depth;
        w_rf_we   = 1'b0;
        w_rf_wa   = '0;
        w_rf_wd   = '0;
        w_stk_we  = 1'b0;
        w_stk_wd  = '0;
        w_need_md = 1'b0;
        unique case (sra_pkg::t_cmd'(r_cmd))
            sra_pkg::CMD_PUSH_VAL, sra_pkg::CMD_PUSH_REG: begin
                if ((r_cmd == sra_pkg::CMD_PUSH_REG) && !w_a_ok) begin
                    n_st = sra_pkg::ST_BAD_INDEX;
                end else begin
                    w_stk_we = 1'b1;
                    w_stk_wd = (r_cmd == sra_pkg::CMD_PUSH_REG) ? w_x : w_imm;
                    n_top    = w_top_inc;
                    n_depth  = w_full ? r_depth : r_depth + 1'b1;
                end
            end
            sra_pkg::CMD_POP: begin
                if (!w_a_ok) begin
                    n_st = sra_pkg::ST_BAD_INDEX;
                end else if (r_depth == '0) begin
                    n_st = sra_pkg::ST_UNDERFLOW;
                end else begin
                    n_rv    = r_stk_rd;
                    n_top   = w_top_dec;
                    n_depth = r_depth - 1'b1;
                    w_rf_we = 1'b1;
                    w_rf_wa = r_reg_a[IW-1:0];
                    w_rf_wd = r_stk_rd;
                end
            end
            sra_pkg::CMD_ADD, sra_pkg::CMD_SUB, sra_pkg::CMD_MUL, sra_pkg::CMD_DIV: begin
                w_rf_we = 1'b1;
                if (w_a_ok && w_b_ok) begin
                    if (r_cmd == sra_pkg::CMD_ADD) begin
                        n_rv = w_x + w_y;
                    end else if (r_cmd == sra_pkg::CMD_SUB) begin
                        n_rv = w_x - w_y;
                    end else if ((r_cmd == sra_pkg::CMD_DIV) && (w_y == '0)) begin
                        n_st = sra_pkg::ST_DIV_ZERO;
                    end else begin
                        w_need_md = 1'b1;
                        n_rv      = w_md_result;
                    end
                end
                w_rf_wd = n_rv;
            end
            sra_pkg::CMD_SET: begin
                if (!w_a_ok) begin
                    n_st = sra_pkg::ST_BAD_INDEX;
                end else begin
                    w_rf_we = 1'b1;
                    w_rf_wa = r_reg_a[IW-1:0];
                    w_rf_wd = w_imm;
                end
            end
            sra_pkg::CMD_PEEK: begin
                if (r_depth == '0) begin
                    n_st = sra_pkg::ST_UNDERFLOW;
                end else begin
                    n_rv = r_stk_rd;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish && w_rf_we) begin
            r_rf_mem[w_rf_wa] <= w_rf_wd;
        end
        r_rd_a   <= r_rf_mem[r_reg_a[IW-1:0]];
        r_rd_b   <= r_rf_mem[r_reg_b[IW-1:0]];
        r_rd_a_v <= r_rf_vld[r_reg_a[IW-1:0]];
        r_rd_b_v <= r_rf_vld[r_reg_b[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish && w_stk_we) begin
            r_stk_mem[r_top] <= w_stk_wd;
        end
        r_stk_rd <= r_stk_mem[w_top_dec];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld  <= '0;
            r_top     <= '0;
            r_depth   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_ctl.finish;
            if (i_ctl.finish) begin
                r_top   <= n_top;
                r_depth <= n_depth;
                if (w_rf_we) begin
                    r_rf_vld[w_rf_wa] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_rv    <= sra_pkg::VAL_W'(n_rv);
            r_out_st    <= n_st;
            r_out_depth <= sra_pkg::DEPTH_W'(n_depth);
        end
    end

    assign o_stat.need_md = w_need_md;
    assign o_stat.md_done = w_md_done;
    assign o_read_value   = r_out_rv;
    assign o_status       = r_out_st;
    assign o_stack_depth  = r_out_depth;
    assign o_done         = r_out_vld;

`ifndef SYNTHESIS
    a_strobe_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(i_ctl.finish))
        else $error("result strobe without a finishing beat");
    a_finish_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.finish |-> !w_md_run)
        else $error("finish while multiply/divide still running");
    a_depth_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.finish |=> $stable(r_depth) && $stable(r_top))
        else $error("stack pointer moved outside a finishing beat");
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= LAST_SLOT)
        else $error("stack depth beyond capacity");
`endif

endmodule

>>> rtl/sra_ctrl.sv
// Controller state machine: accept, operand read, execute, multiply/divide wait.
module sra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sra_pkg::t_dp_stat i_stat,
    output logic              o_busy,
    output sra_pkg::t_ctl     o_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MULDIV
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_ctl.load     = (r_state == S_IDLE) && i_start;
        o_ctl.md_start = (r_state == S_EXEC) && i_stat.need_md;
        o_ctl.finish   = ((r_state == S_EXEC) && !i_stat.need_md)
                      || ((r_state == S_MULDIV) && i_stat.md_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_READ;
                        r_busy  <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (i_stat.need_md) begin
                        r_state <= S_MULDIV;
                    end else begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_MULDIV: begin
                    if (i_stat.md_done) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;

endmodule

>>> rtl/stack_register_alu_unit.sv
// Top level of the stack ALU: one operation per beat, result on a one-cycle strobe.
// Steps: the command is registered on the accepting edge, operands are read into registers
// in READ, and EXEC registers the result with the strobe, unless the mul/div unit runs (mul,
// or div by nonzero, both indexes in range): then MULDIV waits for it, one bit per cycle.
// A new beat may be taken in the cycle its predecessor's result is strobed.
// Synchronous active-low reset empties the stack and zeroes the register file at once.
module stack_register_alu_unit #(
    parameter int STACK_DEPTH = sra_pkg::STACK_DEPTH,
    parameter int REG_COUNT   = sra_pkg::REG_COUNT,
    parameter int WORD_WIDTH  = sra_pkg::WORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic        [sra_pkg::CMD_W-1:0]   i_cmd,
    input  logic        [sra_pkg::IDX_W-1:0]   i_reg_a,
    input  logic        [sra_pkg::IDX_W-1:0]   i_reg_b,
    input  logic signed [sra_pkg::VAL_W-1:0]   i_value,
    output logic                              o_done,
    output logic signed [sra_pkg::VAL_W-1:0]   o_read_value,
    output logic        [sra_pkg::ST_W-1:0]    o_status,
    output logic        [sra_pkg::DEPTH_W-1:0] o_stack_depth
);

    sra_pkg::t_ctl     w_ctl;
    sra_pkg::t_dp_stat w_stat;

    sra_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (w_stat),
        .o_busy (busy),
        .o_ctl  (w_ctl)
    );

    sra_datapath #(
        .STACK_DEPTH(STACK_DEPTH),
        .REG_COUNT  (REG_COUNT),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .o_stat       (w_stat),
        .i_cmd        (i_cmd),
        .i_reg_a      (i_reg_a),
        .i_reg_b      (i_reg_b),
        .i_value      (i_value),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_stack_depth(o_stack_depth),
        .o_done       (o_done)
    );

endmodule
